>>> src/p2h_pkg.sv
// ----------------------------------------------------------------------------
// p2h_pkg
// Shared types and constants for the PS/2 host transceiver.
// ----------------------------------------------------------------------------
`default_nettype none

package p2h_pkg;

   localparam int unsigned CSR_IDX_W           = 4;
   localparam int unsigned CSR_DATA_W          = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RTS_HOLD   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SETUP = 4'd1;

   localparam logic [15:0] RTS_HOLD_RESET   = 16'd150;
   localparam logic [15:0] DATA_SETUP_RESET = 16'd5;
   localparam logic [7:0]  RESEND_CMD       = 8'hFE;
   localparam logic [3:0]  LAST_BIT_COUNT   = 4'd8;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RX_DATA   = 4'd1,
      PH_RX_PAR    = 4'd2,
      PH_RX_STOP   = 4'd3,
      PH_TX_RTS    = 4'd4,
      PH_TX_SETUP  = 4'd5,
      PH_TX_START  = 4'd6,
      PH_TX_BITS   = 4'd7,
      PH_TX_PAR    = 4'd8,
      PH_TX_ACKLO  = 4'd9,
      PH_TX_ACKHI  = 4'd10,
      PH_TX_CLKREL = 4'd11
   } phase_type;

   typedef struct packed {
      logic       action;
      logic [7:0] cmd_byte;
      logic       clk_line;
      logic       data_line;
   } item_type;

   typedef struct packed {
      logic       clk_drive_low;
      logic       data_drive_low;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       parity_error;
      logic       busy_res;
      logic       tx_done;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/p2h_front.sv
// ----------------------------------------------------------------------------
// p2h_front
// Input side: takes items from the request channel and queues them for the
// line engine.
// ----------------------------------------------------------------------------
`default_nettype none

module p2h_front #(
   parameter int unsigned QUEUE_DEPTH = p2h_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_action,
   input  wire logic [7:0]        req_cmd_byte,
   input  wire logic              req_clk_line,
   input  wire logic              req_data_line,
   output logic                   item_valid,
   output p2h_pkg::item_type      item,
   input  wire logic              item_pop
);
   import p2h_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   item_type         req_item;

   assign req_item.action    = req_action;
   assign req_item.cmd_byte  = req_cmd_byte;
   assign req_item.clk_line  = req_clk_line;
   assign req_item.data_line = req_data_line;

   assign req_ready  = (count_ff != CNT_FULL);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (!push && item_pop) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

`default_nettype wire

>>> src/p2h_engine.sv
// ----------------------------------------------------------------------------
// p2h_engine
// Line engine: frame receive, command send with request-to-send, and the
// registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module p2h_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [p2h_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [p2h_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              item_valid,
   input  wire p2h_pkg::item_type                 item,
   output logic                                   item_pop,
   output logic                                   rsp_valid,
   output p2h_pkg::rsp_type                       rsp,
   input  wire logic                              rsp_ready
);
   import p2h_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_reg_ff, shift_reg_in;
   logic        parity_ff, parity_in;
   logic [15:0] delay_ff, delay_in;
   logic        last_clk_ff, last_clk_in;
   logic [15:0] rts_hold_ff;
   logic [15:0] data_setup_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        fire;

   assign csr_ready = 1'b1;
   assign fire      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop  = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      logic        fall;
      logic [15:0] delay_inc;
      logic [3:0]  bit_inc;
      rsp_type     res;

      fall          = last_clk_ff && !item.clk_line;
      delay_inc     = delay_ff + 16'd1;
      bit_inc       = bit_count_ff + 4'd1;
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_reg_in  = shift_reg_ff;
      parity_in     = parity_ff;
      delay_in      = delay_ff;
      last_clk_in   = last_clk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      res           = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (item.action) begin
               phase_in     = PH_TX_RTS;
               delay_in     = '0;
               shift_reg_in = item.cmd_byte;
               parity_in    = 1'b1;
               bit_count_in = '0;
            end else if (fall && !item.data_line) begin
               phase_in     = PH_RX_DATA;
               bit_count_in = '0;
               shift_reg_in = '0;
               parity_in    = 1'b1;
            end
         end
         PH_RX_DATA: begin
            if (fall) begin
               shift_reg_in = {item.data_line, shift_reg_ff[7:1]};
               parity_in    = parity_ff ^ item.data_line;
               bit_count_in = bit_inc;
               if (bit_inc >= LAST_BIT_COUNT) begin
                  phase_in = PH_RX_PAR;
               end
            end
         end
         PH_RX_PAR: begin
            if (fall) begin
               parity_in = (item.data_line == parity_ff);
               phase_in  = PH_RX_STOP;
            end
         end
         PH_RX_STOP: begin
            if (fall) begin
               if (parity_ff) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = shift_reg_ff;
                  phase_in     = PH_IDLE;
                  parity_in    = 1'b1;
               end else begin
                  res.parity_error = 1'b1;
                  phase_in         = PH_TX_RTS;
                  delay_in         = '0;
                  shift_reg_in     = RESEND_CMD;
                  parity_in        = 1'b1;
                  bit_count_in     = '0;
               end
            end
         end
         PH_TX_RTS: begin
            delay_in = delay_inc;
            if (delay_inc >= rts_hold_ff) begin
               phase_in = PH_TX_SETUP;
               delay_in = '0;
            end
         end
         PH_TX_SETUP: begin
            delay_in = delay_inc;
            if (delay_inc >= data_setup_ff) begin
               phase_in = PH_TX_START;
               delay_in = '0;
            end
         end
         PH_TX_START: begin
            if (fall) begin
               phase_in     = PH_TX_BITS;
               bit_count_in = '0;
            end
         end
         PH_TX_BITS: begin
            if (fall) begin
               parity_in    = parity_ff ^ shift_reg_ff[0];
               shift_reg_in = {1'b0, shift_reg_ff[7:1]};
               bit_count_in = bit_inc;
               if (bit_inc >= LAST_BIT_COUNT) begin
                  phase_in = PH_TX_PAR;
               end
            end
         end
         PH_TX_PAR: begin
            if (fall) begin
               phase_in = PH_TX_ACKLO;
            end
         end
         PH_TX_ACKLO: begin
            if (!item.data_line) begin
               phase_in = PH_TX_ACKHI;
            end
         end
         PH_TX_ACKHI: begin
            if (item.data_line) begin
               phase_in = PH_TX_CLKREL;
            end
         end
         PH_TX_CLKREL: begin
            if (item.clk_line) begin
               res.tx_done = 1'b1;
               phase_in    = PH_IDLE;
               parity_in   = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      last_clk_in = item.clk_line;

      unique case (phase_in)
         PH_TX_RTS: begin
            res.clk_drive_low = 1'b1;
         end
         PH_TX_SETUP: begin
            res.clk_drive_low  = 1'b1;
            res.data_drive_low = 1'b1;
         end
         PH_TX_START: begin
            res.data_drive_low = 1'b1;
         end
         PH_TX_BITS: begin
            res.data_drive_low = !shift_reg_in[0];
         end
         PH_TX_PAR: begin
            res.data_drive_low = !parity_in;
         end
         default: begin
         end
      endcase
      res.busy_res = (phase_in != PH_IDLE);

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else begin
         phase_in     = phase_ff;
         bit_count_in = bit_count_ff;
         shift_reg_in = shift_reg_ff;
         parity_in    = parity_ff;
         delay_in     = delay_ff;
         last_clk_in  = last_clk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_reg_ff <= '0;
         parity_ff    <= 1'b1;
         delay_ff     <= '0;
         last_clk_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_reg_ff <= shift_reg_in;
         parity_ff    <= parity_in;
         delay_ff     <= delay_in;
         last_clk_ff  <= last_clk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rts_hold_ff   <= RTS_HOLD_RESET;
         data_setup_ff <= DATA_SETUP_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_RTS_HOLD) begin
            rts_hold_ff <= csr_wdata;
         end
         if (csr_index == CSR_DATA_SETUP) begin
            data_setup_ff <= csr_wdata;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/ps2_host_transceiver.sv
// ----------------------------------------------------------------------------
// ps2_host_transceiver
// PS/2 host line engine: receives device frames, sends command bytes.
// ----------------------------------------------------------------------------
// Each request item is one tick of line samples (plus an optional send
// command) and yields exactly one response item with the line drives and
// status for that tick. Items flow at one per clock when nothing stalls: a
// QUEUE_DEPTH-entry queue feeds the line engine, which steps once per item
// and registers its result, so each request is held in the queue register
// and then in the response register before its response is presented.
// Register writes on the csr_ channel are never stalled.
`default_nettype none

module ps2_host_transceiver #(
   parameter int unsigned QUEUE_DEPTH = p2h_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [p2h_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [p2h_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic [7:0]                        req_cmd_byte,
   input  wire logic                              req_clk_line,
   input  wire logic                              req_data_line,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_clk_drive_low,
   output logic                                   rsp_data_drive_low,
   output logic                                   rsp_rx_valid,
   output logic [7:0]                             rsp_rx_byte,
   output logic                                   rsp_parity_error,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_tx_done
);
   import p2h_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_pop;
   rsp_type  rsp;

   p2h_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_cmd_byte  (req_cmd_byte),
      .req_clk_line  (req_clk_line),
      .req_data_line (req_data_line),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   p2h_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .rsp_ready  (rsp_ready)
   );

   assign rsp_clk_drive_low  = rsp.clk_drive_low;
   assign rsp_data_drive_low = rsp.data_drive_low;
   assign rsp_rx_valid       = rsp.rx_valid;
   assign rsp_rx_byte        = rsp.rx_byte;
   assign rsp_parity_error   = rsp.parity_error;
   assign rsp_busy_res       = rsp.busy_res;
   assign rsp_tx_done        = rsp.tx_done;

endmodule

`default_nettype wire

>>> src/p2h_checker.sv
// ----------------------------------------------------------------------------
// p2h_checker
// Port-level checks for the PS/2 host transceiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module p2h_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_clk_drive_low,
   input wire logic       rsp_data_drive_low,
   input wire logic       rsp_rx_valid,
   input wire logic [7:0] rsp_rx_byte,
   input wire logic       rsp_parity_error,
   input wire logic       rsp_busy_res,
   input wire logic       rsp_tx_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte)
         && $stable(rsp_busy_res) && $stable(rsp_clk_drive_low))
      else $error("response changed while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_done |-> !rsp_busy_res && !rsp_clk_drive_low)
      else $error("tx done while still busy");

   a_rx_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> !rsp_busy_res && !rsp_parity_error)
      else $error("rx byte reported while busy");

   a_resend_rts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parity_error |-> rsp_busy_res && rsp_clk_drive_low
         && !rsp_data_drive_low)
      else $error("parity error without request-to-send");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_clk_drive_low && !rsp_data_drive_low)
      else $error("line driven while idle");

endmodule

bind ps2_host_transceiver p2h_checker u_p2h_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_clk_drive_low  (rsp_clk_drive_low),
   .rsp_data_drive_low (rsp_data_drive_low),
   .rsp_rx_valid       (rsp_rx_valid),
   .rsp_rx_byte        (rsp_rx_byte),
   .rsp_parity_error   (rsp_parity_error),
   .rsp_busy_res       (rsp_busy_res),
   .rsp_tx_done        (rsp_tx_done)
);

`default_nettype wire
